// ===== src/plstore_pkg.sv =====
package plstore_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_SEARCH = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_CHECK = 2'd1,
    S_WALK  = 2'd2,
    S_DONE  = 2'd3
  } state_t;

  localparam int DATA_W  = 32;
  localparam int POS_W   = 5;
  localparam int COUNT_W = 5;

  typedef struct packed {
    status_t             status;
    logic [DATA_W-1:0]   read_value;
    logic                found;
  } res_t;

endpackage

// ===== src/plstore_ram.sv =====
module plstore_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/plstore_ctrl.sv =====
module plstore_ctrl #(
  parameter int CAPACITY = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     start,
  output logic                                     busy,
  input  logic [1:0]                               cmd,
  input  logic [plstore_pkg::POS_W-1:0]            position,
  input  logic [plstore_pkg::DATA_W-1:0]           value,
  output logic                                     ram_we,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] ram_waddr,
  output logic [plstore_pkg::DATA_W-1:0]           ram_wdata,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] ram_raddr,
  input  logic [plstore_pkg::DATA_W-1:0]           ram_rdata,
  output logic                                     res_valid,
  output plstore_pkg::res_t                        res,
  output logic [$clog2(CAPACITY+1)-1:0]            res_count
);
  import plstore_pkg::*;

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam int PTRW = AW + 1;

  state_t            state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [PTRW-1:0]   ptr_r, ptr_nxt;
  logic [CW-1:0]     rem_r, rem_nxt;
  logic              pv_r, pv_nxt;
  logic [AW-1:0]     pa_r, pa_nxt;
  logic              hit_r, hit_nxt;
  logic [DATA_W-1:0] rdv_r, rdv_nxt;
  status_t           status_r, status_nxt;

  logic [CMPW-1:0]   cnt_e, pos_e;

  assign cnt_e = CMPW'(cnt_r);
  assign pos_e = CMPW'(pos_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      pv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pv_r    <= pv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    pos_r    <= pos_nxt;
    val_r    <= val_nxt;
    ptr_r    <= ptr_nxt;
    rem_r    <= rem_nxt;
    pa_r     <= pa_nxt;
    hit_r    <= hit_nxt;
    rdv_r    <= rdv_nxt;
    status_r <= status_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    pos_nxt    = pos_r;
    val_nxt    = val_r;
    cnt_nxt    = cnt_r;
    ptr_nxt    = ptr_r;
    rem_nxt    = rem_r;
    pv_nxt     = 1'b0;
    pa_nxt     = pa_r;
    hit_nxt    = hit_r;
    rdv_nxt    = rdv_r;
    status_nxt = status_r;
    ram_we     = 1'b0;
    ram_waddr  = pa_r;
    ram_wdata  = ram_rdata;
    ram_raddr  = ptr_r[AW-1:0];
    res_valid  = 1'b0;
    res.status     = status_r;
    res.read_value = rdv_r;
    res.found      = hit_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt   = cmd_t'(cmd);
          pos_nxt   = position;
          val_nxt   = value;
          state_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        hit_nxt    = 1'b0;
        rdv_nxt    = '0;
        status_nxt = ST_OK;
        rem_nxt    = '0;
        ptr_nxt    = '0;
        state_nxt  = S_WALK;
        unique case (cmd_r)
          CMD_INSERT: begin
            if (cnt_e >= CMPW'(CAPACITY)) begin
              status_nxt = ST_FULL;
              state_nxt  = S_DONE;
            end else if (pos_e > cnt_e) begin
              status_nxt = ST_BADPOS;
              state_nxt  = S_DONE;
            end else begin
              // walk down from the last entry, moving each one up a slot
              rem_nxt = CW'(cnt_e - pos_e);
              ptr_nxt = PTRW'(cnt_e - CMPW'(1));
            end
          end
          CMD_REMOVE: begin
            if (cnt_r == '0) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_DONE;
            end else if (pos_e >= cnt_e) begin
              status_nxt = ST_BADPOS;
              state_nxt  = S_DONE;
            end else begin
              rem_nxt = CW'(cnt_e - pos_e - CMPW'(1));
              ptr_nxt = PTRW'(pos_e + CMPW'(1));
            end
          end
          CMD_READ: begin
            if (pos_e >= cnt_e) begin
              status_nxt = ST_BADPOS;
              state_nxt  = S_DONE;
            end else begin
              rem_nxt = CW'(1);
              ptr_nxt = PTRW'(pos_e);
            end
          end
          CMD_SEARCH: begin
            rem_nxt = cnt_r;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      S_WALK: begin
        // one read issued per cycle; data from the previous read is consumed
        if (rem_r != '0) begin
          pv_nxt  = 1'b1;
          pa_nxt  = ptr_r[AW-1:0];
          rem_nxt = rem_r - CW'(1);
          ptr_nxt = (cmd_r == CMD_INSERT) ? (ptr_r - PTRW'(1)) : (ptr_r + PTRW'(1));
        end
        if (pv_r) begin
          unique case (cmd_r)
            CMD_INSERT: begin
              ram_we    = 1'b1;
              ram_waddr = pa_r + AW'(1);
            end
            CMD_REMOVE: begin
              ram_we    = 1'b1;
              ram_waddr = pa_r - AW'(1);
            end
            CMD_READ: begin
              rdv_nxt = ram_rdata;
            end
            CMD_SEARCH: begin
              if (ram_rdata == val_r) begin
                hit_nxt = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        if ((rem_r == '0) && !pv_r) begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (status_r == ST_OK) begin
          if (cmd_r == CMD_INSERT) begin
            ram_we    = 1'b1;
            ram_waddr = pos_e[AW-1:0];
            ram_wdata = val_r;
            cnt_nxt   = cnt_r + CW'(1);
          end else if (cmd_r == CMD_REMOVE) begin
            cnt_nxt = cnt_r - CW'(1);
          end
        end
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign res_count = cnt_nxt;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_e <= CMPW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_refused_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && status_r != ST_OK) |=> $stable(cnt_r))
    else $error("refused command changed the count");

  a_walk_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && rem_r == '0 && !pv_r) |=> (state_r == S_DONE))
    else $error("walk did not finish after last beat");

endmodule

// ===== src/positional_list_store.sv =====
// Command in, one result out per command; results cannot be stalled.
// A refused command goes from the check to the result beat; an accepted one
// first walks its entries: count - position for insert, count - position - 1
// for remove, 1 for read and count for search. busy drops with the result
// beat, so the next command is taken no earlier than the previous result beat.
// rst_n (synchronous) empties the list; list storage itself is not cleared.
module positional_list_store #(
  parameter int CAPACITY = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  output logic                                    busy,
  input  logic [1:0]                              in_cmd,
  input  logic [plstore_pkg::POS_W-1:0]           in_position,
  input  logic signed [plstore_pkg::DATA_W-1:0]   in_value,
  output logic                                    out_strobe,
  output logic [1:0]                              out_status,
  output logic signed [plstore_pkg::DATA_W-1:0]   out_read_value,
  output logic                                    out_found,
  output logic [plstore_pkg::COUNT_W-1:0]         out_count
);
  import plstore_pkg::*;

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > COUNT_W) ? CW : COUNT_W;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;
  logic              res_valid;
  res_t              res;
  logic [CW-1:0]     res_count;
  logic [CMPW-1:0]   res_count_e;

  logic              strobe_r;
  status_t           status_r;
  logic [DATA_W-1:0] rv_r;
  logic              found_r;
  logic [COUNT_W-1:0] count_r;

  plstore_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cmd       (in_cmd),
    .position  (in_position),
    .value     (in_value),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res       (res),
    .res_count (res_count)
  );

  plstore_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // count is reported modulo the field width
  assign res_count_e = CMPW'(res_count);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      status_r <= res.status;
      rv_r     <= res.read_value;
      found_r  <= res.found;
      count_r  <= res_count_e[COUNT_W-1:0];
    end
  end

  assign out_strobe     = strobe_r;
  assign out_status     = status_r;
  assign out_read_value = rv_r;
  assign out_found      = found_r;
  assign out_count      = count_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_found_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_found) |-> (out_status == ST_OK && out_read_value == '0))
    else $error("found flag with bad status or read data");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result beat held longer than one cycle");

endmodule
